>>> hw/rtl/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg: shared types and constants of the indexed list unit
// command codes, status codes, beat layout and the per-cell control bundle
// ----------------------------------------------------------------------------
package ili_pkg;

  // field widths of one beat
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 5;

  // packed beat widths, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = ((CMD_W + POS_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((VAL_W + STAT_W + CNT_W + 7) / 8) * 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_GET      = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_AT   = 3'd3,
    CMD_DEL_AT   = 3'd4,
    CMD_DEL_HEAD = 3'd5
  } cmd_t;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ili_cell.sv
// ----------------------------------------------------------------------------
// ili_cell: one slot of the list
// holds one entry, takes its left or right neighbor or the new value on insert or delete
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  logic                      clk,
  input  ili_pkg::cell_ctrl_t       ctrl,
  input  logic [IW-1:0]             at,
  input  logic [IW-1:0]             rd_at,
  input  logic [ili_pkg::VAL_W-1:0] left_val,
  input  logic [ili_pkg::VAL_W-1:0] right_val,
  output logic [ili_pkg::VAL_W-1:0] value_q,
  output logic [ili_pkg::VAL_W-1:0] rd_val
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [ili_pkg::VAL_W-1:0] value_r;
  logic [ili_pkg::VAL_W-1:0] value_nxt;

  // shift right behind an insert point, shift left from a delete point
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (MY_IDX > at) begin
        value_nxt = left_val;
      end else if (MY_IDX == at) begin
        value_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= at) begin
        value_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_q = value_r;

  // entry gated onto the read bus when this slot is addressed
  assign rd_val = (MY_IDX == rd_at) ? value_r : '0;

endmodule

>>> hw/rtl/indexed_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit: ordered list with positional access
// row of cells holding up to CAPACITY signed entries plus an entry count
// ----------------------------------------------------------------------------
// The unit takes one command beat per clock and returns one result beat from
// an output register in the next cycle; with out_tready held high it sustains
// one beat per cycle, and in_tready drops only while a finished result waits
// unclaimed. Every insert or delete moves all entries behind the point by one
// place at once through the row of cells, each cell loading from its left or
// right neighbor, so the command mix never changes the rate. A get returns the
// addressed entry through an OR of the cell outputs. No clearing pass is
// needed after reset: only entries below the count are ever read.
module indexed_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // slave side
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ili_pkg::IN_DATA_W-1:0]  in_tdata,   // command, position, item_value
  // master side
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ili_pkg::OUT_DATA_W-1:0] out_tdata   // read_value, status, entry_count
);

  localparam int unsigned IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = ili_pkg::POS_W - 1;
  localparam int unsigned OPAD = ili_pkg::OUT_DATA_W
                               - (ili_pkg::VAL_W + ili_pkg::STAT_W + ili_pkg::CNT_W);

  // input beat fields
  logic [ili_pkg::CMD_W-1:0] cmd_raw;
  logic [ili_pkg::POS_W-1:0] position;
  logic [ili_pkg::VAL_W-1:0] item_value;

  assign cmd_raw    = in_tdata[ili_pkg::CMD_W-1:0];
  assign position   = in_tdata[ili_pkg::CMD_W +: ili_pkg::POS_W];
  assign item_value = in_tdata[ili_pkg::CMD_W + ili_pkg::POS_W +: ili_pkg::VAL_W];

  logic                      accept;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic                      out_valid_r;
  logic [ili_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [ili_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic                      neg;
  logic [PW-1:0]             pos;
  logic [PW-1:0]             cnt_ext;
  logic                      full;
  logic                      get_ok;
  logic [ili_pkg::VAL_W-1:0] rd;
  logic [ili_pkg::STAT_W-1:0] st;
  logic                      do_ins;
  logic                      do_del;
  logic [IW-1:0]             at;
  logic [IW-1:0]             rd_at;
  logic [ili_pkg::VAL_W-1:0] rd_bus;
  ili_pkg::cell_ctrl_t       ctrl;

  logic [ili_pkg::VAL_W-1:0] cell_val [CAPACITY];
  logic [ili_pkg::VAL_W-1:0] cell_rd  [CAPACITY];

  // input is free while the output register is empty or its result is being taken
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign neg     = position[ili_pkg::POS_W-1];
  assign pos     = position[PW-1:0];
  assign cnt_ext = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign get_ok  = !neg && (pos < cnt_ext);
  assign rd_at   = pos[IW-1:0];

  // command decode
  always_comb begin
    rd     = '0;
    st     = ili_pkg::ST_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    at     = '0;
    case (ili_pkg::cmd_t'(cmd_raw))
      ili_pkg::CMD_GET: begin
        if (get_ok) begin
          rd = rd_bus;
        end else begin
          rd = '1;
          st = ili_pkg::ST_RANGE;
        end
      end
      ili_pkg::CMD_INS_HEAD: begin
        if (full) begin
          st = ili_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ili_pkg::CMD_INS_TAIL: begin
        if (full) begin
          st = ili_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          at     = count_r[IW-1:0];
        end
      end
      ili_pkg::CMD_INS_AT: begin
        if (neg || (pos > cnt_ext)) begin
          st = ili_pkg::ST_RANGE;
        end else if (full) begin
          st = ili_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          at     = pos[IW-1:0];
        end
      end
      ili_pkg::CMD_DEL_AT: begin
        if (!get_ok) begin
          st = ili_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
          at     = pos[IW-1:0];
        end
      end
      ili_pkg::CMD_DEL_HEAD: begin
        if (count_r == '0) begin
          st = ili_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        st = ili_pkg::ST_RANGE;
      end
    endcase
  end

  // cell control, only on an accepted beat
  assign ctrl.ins   = accept && do_ins;
  assign ctrl.del   = accept && do_del;
  assign ctrl.value = item_value;

  // count update
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ili_pkg::VAL_W-1:0] left_v;
    logic [ili_pkg::VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ili_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .at        (at),
      .rd_at     (rd_at),
      .left_val  (left_v),
      .right_val (right_v),
      .value_q   (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  // read bus: at most one cell drives a nonzero value
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // result beat
  assign out_data_nxt = {{OPAD{1'b0}}, ili_pkg::CNT_W'(count_nxt), st, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
